// ===== hw/rtl/dcfl_pkg.sv =====
// dcfl_pkg: shared constants, codes and types of the descriptor chain free list
// no dependencies; compiled first

package dcfl_pkg;

	localparam int QUEUE_DEPTH = 256;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// status codes
	localparam logic ST_OK    = 1'b0;
	localparam logic ST_SHORT = 1'b1;

	// one descriptor table entry: link mark and next link
	typedef struct packed {
		logic             mark;
		logic [IDX_W-1:0] link;
	} desc_entry_t;

	// access from the sequencer to the descriptor table
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		desc_entry_t      wr_data;
	} store_req_t;

	// one response
	typedef struct packed {
		logic             status;
		logic [IDX_W-1:0] chain_head;
		logic [CNT_W-1:0] free_count;
	} rsp_t;

endpackage

// ===== hw/rtl/dcfl_if.sv =====
// dcfl_if: valid/ready channel interfaces for commands, responses and queue size writes
// depends on dcfl_pkg

interface dcfl_cmd_if;
	import dcfl_pkg::*;
	logic             valid;
	logic             ready;
	logic             command;
	logic [CNT_W-1:0] chain_length;
	logic [IDX_W-1:0] release_head;
	modport source (output valid, command, chain_length, release_head, input ready);
	modport sink   (input valid, command, chain_length, release_head, output ready);
endinterface

interface dcfl_rsp_if;
	import dcfl_pkg::*;
	logic             valid;
	logic             ready;
	logic             status;
	logic [IDX_W-1:0] chain_head;
	logic [CNT_W-1:0] free_count;
	modport source (output valid, status, chain_head, free_count, input ready);
	modport sink   (input valid, status, chain_head, free_count, output ready);
endinterface

interface dcfl_cfg_if;
	import dcfl_pkg::*;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ===== hw/rtl/dcfl_store.sv =====
// dcfl_store: descriptor table memory with per-entry valid bits and same-entry bypass
// depends on dcfl_pkg

module dcfl_store (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    rebuild,
	input  logic [dcfl_pkg::CNT_W-1:0] qsize,
	input  dcfl_pkg::store_req_t    req,
	output dcfl_pkg::desc_entry_t   rdata
);
	import dcfl_pkg::*;

	desc_entry_t            mem [QUEUE_DEPTH];
	desc_entry_t            mem_q;
	logic [QUEUE_DEPTH-1:0] vld_q;
	logic                   hit_q;
	logic                   byp_q;
	desc_entry_t            byp_data_q;
	desc_entry_t            dflt_q;
	logic [CNT_W-1:0]       succ;
	desc_entry_t            dflt;

	// value of an entry not written since the last rebuild
	assign succ      = {1'b0, req.rd_addr} + CNT_W'(1);
	assign dflt.mark = 1'b0;
	assign dflt.link = (succ == qsize) ? '0 : succ[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (req.wr_en)
			mem[req.wr_addr] <= req.wr_data;
		if (req.rd_en)
			mem_q <= mem[req.rd_addr];
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			byp_data_q <= req.wr_data;
			dflt_q     <= dflt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
			byp_q <= 1'b0;
		end else begin
			if (req.rd_en) begin
				hit_q <= vld_q[req.rd_addr];
				byp_q <= req.wr_en && (req.wr_addr == req.rd_addr);
			end
			if (rebuild)
				vld_q <= '0;
			else if (req.wr_en)
				vld_q[req.wr_addr] <= 1'b1;
		end
	end

	assign rdata = byp_q ? byp_data_q : (hit_q ? mem_q : dflt_q);

endmodule

// ===== hw/rtl/dcfl_walk.sv =====
// dcfl_walk: command sequencer that walks the descriptor table, keeps head, count and size
// depends on dcfl_pkg and the channel interfaces

module dcfl_walk (
	input  logic                  clk,
	input  logic                  arst_n,
	dcfl_cmd_if.sink              cmd,
	dcfl_cfg_if.sink              cfg,
	output dcfl_pkg::store_req_t  sreq,
	output logic                  rebuild,
	output logic [dcfl_pkg::CNT_W-1:0] qsize,
	input  dcfl_pkg::desc_entry_t rdata,
	output logic                  res_valid,
	input  logic                  res_ready,
	output dcfl_pkg::rsp_t        res
);
	import dcfl_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] qsize_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] free_q;
	logic             op_q;
	logic [IDX_W-1:0] cur_q;
	logic [IDX_W-1:0] start_q;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] cnt_q;
	rsp_t             res_q;

	logic             accept;
	logic [CNT_W-1:0] size_new;
	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W:0]   sum;
	logic [CNT_W-1:0] sum_sat;
	logic             more;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rebuild   = cfg.valid;
	assign qsize     = qsize_q;
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	// out-of-range sizes fold into 1..QUEUE_DEPTH
	always_comb begin
		size_new = cfg.data;
		if (cfg.data == '0)
			size_new = CNT_W'(1);
		else if (cfg.data > CNT_W'(QUEUE_DEPTH))
			size_new = CNT_W'(QUEUE_DEPTH);
	end

	assign cnt_inc = cnt_q + CNT_W'(1);
	assign sum     = {1'b0, free_q} + {1'b0, cnt_q};
	assign sum_sat = (sum > {1'b0, qsize_q}) ? qsize_q : sum[CNT_W-1:0];
	// free walk continues while the mark is set and the size bound is not hit
	assign more    = rdata.mark && (cnt_q < qsize_q);

	always_comb begin
		sreq = '0;
		if (state_q == S_IDLE && accept) begin
			if (cmd.command == CMD_ALLOC) begin
				sreq.rd_en   = (cmd.chain_length != '0) && (free_q >= cmd.chain_length);
				sreq.rd_addr = head_q;
			end else begin
				sreq.rd_en   = ({1'b0, cmd.release_head} < qsize_q);
				sreq.rd_addr = cmd.release_head;
			end
		end else if (state_q == S_WALK) begin
			sreq.wr_addr = cur_q;
			sreq.rd_addr = rdata.link;
			if (op_q == CMD_ALLOC) begin
				sreq.wr_en        = 1'b1;
				sreq.wr_data.mark = (cnt_inc < len_q);
				sreq.wr_data.link = rdata.link;
				sreq.rd_en        = (cnt_inc != len_q);
			end else if (more) begin
				sreq.rd_en = 1'b1;
			end else begin
				sreq.wr_en        = 1'b1;
				sreq.wr_data.mark = rdata.mark;
				sreq.wr_data.link = head_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q             <= cmd.command;
					len_q            <= cmd.chain_length;
					res_q.free_count <= free_q;
					if (cmd.command == CMD_ALLOC) begin
						cur_q   <= head_q;
						start_q <= head_q;
						cnt_q   <= '0;
						if (free_q < cmd.chain_length) begin
							res_q.status     <= ST_SHORT;
							res_q.chain_head <= '0;
						end else begin
							res_q.status     <= ST_OK;
							res_q.chain_head <= head_q;
						end
					end else begin
						cur_q            <= cmd.release_head;
						start_q          <= cmd.release_head;
						cnt_q            <= CNT_W'(1);
						res_q.status     <= ST_OK;
						res_q.chain_head <= '0;
					end
				end
			end
			S_WALK: begin
				cur_q <= rdata.link;
				cnt_q <= cnt_inc;
				if (op_q == CMD_ALLOC)
					res_q.free_count <= free_q - len_q;
				else
					res_q.free_count <= sum_sat;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			qsize_q <= CNT_W'(QUEUE_DEPTH);
			head_q  <= '0;
			free_q  <= CNT_W'(QUEUE_DEPTH);
		end else begin
			if (cfg.valid) begin
				qsize_q <= size_new;
				head_q  <= '0;
				free_q  <= size_new;
			end
			case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= sreq.rd_en ? S_WALK : S_DONE;
				end
				S_WALK: begin
					if (op_q == CMD_ALLOC) begin
						if (cnt_inc == len_q) begin
							head_q  <= rdata.link;
							free_q  <= free_q - len_q;
							state_q <= S_DONE;
						end
					end else if (!more) begin
						head_q  <= start_q;
						free_q  <= sum_sat;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/dcfl_out.sv =====
// dcfl_out: response output register between the sequencer and the response channel
// depends on dcfl_pkg and dcfl_rsp_if

module dcfl_out (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           res_valid,
	output logic           res_ready,
	input  dcfl_pkg::rsp_t res,
	dcfl_rsp_if.source     rsp
);
	import dcfl_pkg::*;

	logic valid_q;
	rsp_t data_q;

	assign res_ready = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (res_ready)
			valid_q <= res_valid;
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid)
			data_q <= res;
	end

	assign rsp.valid      = valid_q;
	assign rsp.status     = data_q.status;
	assign rsp.chain_head = data_q.chain_head;
	assign rsp.free_count = data_q.free_count;

endmodule

// ===== hw/rtl/descriptor_chain_free_list.sv =====
// descriptor_chain_free_list: linked free list of queue descriptors, allocate and free chains
// a request is accepted, its descriptors are read from the table one by one, and the response
// is handed to the output register; the next request is taken only after that handoff
// a stalled response holds the output register and delays the next request
// a queue size write rebuilds the list; asynchronous reset does the same with 256
// depends on dcfl_pkg, the channel interfaces, dcfl_store, dcfl_walk and dcfl_out

module descriptor_chain_free_list (
	input  logic     clk,
	input  logic     arst_n,
	dcfl_cmd_if.sink cmd,
	dcfl_cfg_if.sink cfg,
	dcfl_rsp_if.source rsp
);
	import dcfl_pkg::*;

	store_req_t       sreq;
	desc_entry_t      rdata;
	logic             rebuild;
	logic [CNT_W-1:0] qsize;
	logic             res_valid;
	logic             res_ready;
	rsp_t             res;

	dcfl_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rebuild (rebuild),
		.qsize   (qsize),
		.req     (sreq),
		.rdata   (rdata)
	);

	dcfl_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg),
		.sreq      (sreq),
		.rebuild   (rebuild),
		.qsize     (qsize),
		.rdata     (rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	dcfl_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.rsp       (rsp)
	);

endmodule

// ===== hw/rtl/dcfl_checker.sv =====
// dcfl_checker: port-level assertions for descriptor_chain_free_list, bound to the top level
// depends on dcfl_pkg

module dcfl_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cmd_valid,
	input logic                      cmd_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic                      rsp_status,
	input logic [dcfl_pkg::IDX_W-1:0] rsp_chain_head,
	input logic [dcfl_pkg::CNT_W-1:0] rsp_free_count
);
	import dcfl_pkg::*;

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_chain_head) && $stable(rsp_free_count))
		else $error("response changed while stalled");

	// one request in work at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("request taken while another is in work");

	// free count never exceeds the table
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_free_count <= CNT_W'(QUEUE_DEPTH))
		else $error("free count above table depth");

	// a failed allocate reports no head
	a_fail_head: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_SHORT) |-> rsp_chain_head == '0)
		else $error("failed allocate with nonzero head");

endmodule

bind descriptor_chain_free_list dcfl_checker u_dcfl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_chain_head (rsp.chain_head),
	.rsp_free_count (rsp.free_count)
);

// ===== verif/descriptor_chain_free_list_test.sv =====
// descriptor_chain_free_list_test: self-checking bench for the descriptor chain free list
// drives allocate/free requests and queue size writes, predicts every response
// depends on dcfl_pkg, the dcfl channel interfaces and descriptor_chain_free_list

module descriptor_chain_free_list_test;
	import dcfl_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 41;

	typedef struct {
		bit               is_write;
		logic [CNT_W-1:0] size_val;
		logic             command;
		logic [CNT_W-1:0] chain_length;
		logic [IDX_W-1:0] release_head;
		bit               typed;
		rsp_t             want;
	} step_t;

	logic clk;
	logic arst_n;

	dcfl_cmd_if cmd_ch();
	dcfl_cfg_if cfg_ch();
	dcfl_rsp_if rsp_ch();

	descriptor_chain_free_list DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.cfg    (cfg_ch),
		.rsp    (rsp_ch)
	);

	// shadow of the descriptor table and list registers
	logic [IDX_W-1:0] link_tbl [QUEUE_DEPTH];
	logic             mark_tbl [QUEUE_DEPTH];
	logic [IDX_W-1:0] list_head;
	logic [CNT_W-1:0] free_total;
	int               size_in_use;

	rsp_t             due_rsp [$];
	rsp_t             front_rsp;
	logic [IDX_W-1:0] held_chains [$];
	step_t            dir_steps [25];
	int               errors;
	int               cycle_count;
	int               send_quiet;
	int               recv_quiet;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic void rebuild_list(logic [CNT_W-1:0] size_val);
		int s;
		s = size_val;
		if (s == 0)
			s = 1;
		if (s > QUEUE_DEPTH)
			s = QUEUE_DEPTH;
		size_in_use = s;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			link_tbl[i] = '0;
			mark_tbl[i] = 1'b0;
		end
		for (int i = 0; i + 1 < s; i++)
			link_tbl[i] = IDX_W'(i + 1);
		list_head  = '0;
		free_total = CNT_W'(s);
	endfunction

	function automatic rsp_t predict_list_op(logic command, logic [CNT_W-1:0] chain_length,
			logic [IDX_W-1:0] release_head);
		rsp_t r;
		int   cur;
		int   walked;
		r.status     = ST_OK;
		r.chain_head = '0;
		if (command == CMD_ALLOC) begin
			if (free_total < chain_length) begin
				r.status = ST_SHORT;
			end else begin
				cur = list_head;
				r.chain_head = IDX_W'(cur);
				for (int i = 0; i < chain_length; i++) begin
					mark_tbl[cur] = (i + 1 < chain_length);
					cur = link_tbl[cur];
				end
				list_head  = IDX_W'(cur);
				free_total = free_total - chain_length;
			end
		end else if (release_head < size_in_use) begin
			// follow the link marks, bounded by the queue size
			cur    = release_head;
			walked = 1;
			while (mark_tbl[cur] && walked < size_in_use) begin
				cur = link_tbl[cur];
				walked++;
			end
			link_tbl[cur] = list_head;
			list_head     = release_head;
			walked        = walked + free_total;
			if (walked > size_in_use)
				walked = size_in_use;
			free_total = CNT_W'(walked);
		end
		r.free_count = free_total;
		return r;
	endfunction

	function automatic int draw_wait(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			quiet = $urandom_range(10, 40);
		return $urandom_range(0, 16);
	endfunction

	// called and returns at a falling edge; valid stays high when no gap follows
	task automatic send_request(input logic command, input logic [CNT_W-1:0] chain_length,
			input logic [IDX_W-1:0] release_head, input bit typed, input rsp_t typed_rsp,
			output rsp_t predicted);
		int gap;
		gap = draw_wait(send_quiet);
		if (gap > 0) begin
			cmd_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid        = 1'b1;
		cmd_ch.command      = command;
		cmd_ch.chain_length = chain_length;
		cmd_ch.release_head = release_head;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		predicted = predict_list_op(command, chain_length, release_head);
		due_rsp.push_back(typed ? typed_rsp : predicted);
		@(negedge clk);
	endtask

	task automatic drain_responses();
		cmd_ch.valid = 1'b0;
		while (due_rsp.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_queue_size(input logic [CNT_W-1:0] size_val);
		drain_responses();
		repeat (2) @(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.data  = size_val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		rebuild_list(size_val);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
		held_chains.delete();
	endtask

	// response side: random stalls per response
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		forever begin
			stall = draw_wait(recv_quiet);
			if (stall > 0) begin
				rsp_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (due_rsp.size() == 0) begin
				$display("%0t: unexpected response status %0d head %0d free %0d", $time,
					rsp_ch.status, rsp_ch.chain_head, rsp_ch.free_count);
				errors++;
			end else begin
				front_rsp = due_rsp.pop_front();
				if (rsp_ch.status !== front_rsp.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						front_rsp.status, rsp_ch.status);
					errors++;
				end
				if (rsp_ch.chain_head !== front_rsp.chain_head) begin
					$display("%0t: chain_head expected %0d actual %0d", $time,
						front_rsp.chain_head, rsp_ch.chain_head);
					errors++;
				end
				if (rsp_ch.free_count !== front_rsp.free_count) begin
					$display("%0t: free_count expected %0d actual %0d", $time,
						front_rsp.free_count, rsp_ch.free_count);
					errors++;
				end
			end
		end
	end

	initial begin
		rsp_t             got;
		logic [CNT_W-1:0] sizes [11];
		logic [CNT_W-1:0] len;
		logic [IDX_W-1:0] rel;
		logic             op;
		int               pick;
		int               upper;
		int               idx;
		int               items;

		errors      = 0;
		cycle_count = 0;
		send_quiet  = 0;
		recv_quiet  = 0;
		arst_n      = 1'b0;
		cmd_ch.valid        = 1'b0;
		cmd_ch.command      = CMD_ALLOC;
		cmd_ch.chain_length = '0;
		cmd_ch.release_head = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data  = '0;
		rebuild_list(CNT_W'(QUEUE_DEPTH));

		dir_steps = '{
			'{1'b0, 9'd0, CMD_ALLOC, 9'd0,   8'd0,   1'b1, '{ST_OK,    8'd0, 9'd256}},
			'{1'b0, 9'd0, CMD_ALLOC, 9'd511, 8'd0,   1'b1, '{ST_SHORT, 8'd0, 9'd256}},
			'{1'b0, 9'd0, CMD_ALLOC, 9'd257, 8'd0,   1'b1, '{ST_SHORT, 8'd0, 9'd256}},
			'{1'b0, 9'd0, CMD_ALLOC, 9'd3,   8'd0,   1'b1, '{ST_OK,    8'd0, 9'd253}},
			'{1'b0, 9'd0, CMD_ALLOC, 9'd1,   8'd0,   1'b1, '{ST_OK,    8'd3, 9'd252}},
			'{1'b0, 9'd0, CMD_FREE,  9'd0,   8'd0,   1'b0, '{ST_OK,    8'd0, 9'd0}},
			// freeing what was never taken saturates the count
			'{1'b0, 9'd0, CMD_FREE,  9'd0,   8'd255, 1'b1, '{ST_OK,    8'd0, 9'd256}},
			'{1'b0, 9'd0, CMD_FREE,  9'd0,   8'd4,   1'b1, '{ST_OK,    8'd0, 9'd256}},
			'{1'b0, 9'd0, CMD_ALLOC, 9'd256, 8'd0,   1'b0, '{ST_OK,    8'd0, 9'd0}},
			'{1'b0, 9'd0, CMD_ALLOC, 9'd1,   8'd0,   1'b1, '{ST_SHORT, 8'd0, 9'd0}},
			'{1'b0, 9'd0, CMD_FREE,  9'd0,   8'd255, 1'b0, '{ST_OK,    8'd0, 9'd0}},
			'{1'b0, 9'd0, CMD_ALLOC, 9'd0,   8'd0,   1'b0, '{ST_OK,    8'd0, 9'd0}},
			'{1'b0, 9'd0, CMD_ALLOC, 9'd2,   8'd0,   1'b0, '{ST_OK,    8'd0, 9'd0}},
			// size zero is taken as one
			'{1'b1, 9'd0, CMD_ALLOC, 9'd0,   8'd0,   1'b0, '{ST_OK,    8'd0, 9'd0}},
			'{1'b0, 9'd0, CMD_ALLOC, 9'd1,   8'd0,   1'b1, '{ST_OK,    8'd0, 9'd0}},
			'{1'b0, 9'd0, CMD_FREE,  9'd0,   8'd0,   1'b1, '{ST_OK,    8'd0, 9'd1}},
			'{1'b0, 9'd0, CMD_FREE,  9'd0,   8'd1,   1'b1, '{ST_OK,    8'd0, 9'd1}},
			'{1'b0, 9'd0, CMD_FREE,  9'd0,   8'd255, 1'b1, '{ST_OK,    8'd0, 9'd1}},
			'{1'b0, 9'd0, CMD_ALLOC, 9'd2,   8'd0,   1'b1, '{ST_SHORT, 8'd0, 9'd1}},
			// oversized write clamps to the table depth
			'{1'b1, 9'd511, CMD_ALLOC, 9'd0, 8'd0,   1'b0, '{ST_OK,    8'd0, 9'd0}},
			'{1'b0, 9'd0, CMD_ALLOC, 9'd128, 8'd0,   1'b0, '{ST_OK,    8'd0, 9'd0}},
			'{1'b0, 9'd0, CMD_ALLOC, 9'd128, 8'd0,   1'b0, '{ST_OK,    8'd0, 9'd0}},
			'{1'b0, 9'd0, CMD_FREE,  9'd0,   8'd128, 1'b0, '{ST_OK,    8'd0, 9'd0}},
			'{1'b0, 9'd0, CMD_FREE,  9'd0,   8'd0,   1'b0, '{ST_OK,    8'd0, 9'd0}},
			'{1'b0, 9'd0, CMD_ALLOC, 9'd256, 8'd0,   1'b0, '{ST_OK,    8'd0, 9'd0}}
		};

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_steps[i]) begin
			if (dir_steps[i].is_write)
				write_queue_size(dir_steps[i].size_val);
			else
				send_request(dir_steps[i].command, dir_steps[i].chain_length,
					dir_steps[i].release_head, dir_steps[i].typed, dir_steps[i].want, got);
		end

		sizes = '{9'd2, 9'd3, 9'd1, 9'd8, 9'd16, 9'd37, 9'd100, 9'd255, 9'd300, 9'd256, 9'd0};
		sizes[10] = CNT_W'($urandom_range(1, QUEUE_DEPTH));
		items = 0;
		foreach (sizes[p]) begin
			write_queue_size(sizes[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				op   = CMD_ALLOC;
				len  = '0;
				rel  = IDX_W'($urandom_range(0, QUEUE_DEPTH - 1));
				upper = (size_in_use < 6) ? size_in_use : 6;
				if (pick < 45) begin
					len = CNT_W'($urandom_range(1, upper));
				end else if (pick < 85) begin
					if (held_chains.size() != 0) begin
						// release a chain handed out earlier
						idx = $urandom_range(0, held_chains.size() - 1);
						op  = CMD_FREE;
						rel = held_chains[idx];
						held_chains.delete(idx);
					end else begin
						len = CNT_W'($urandom_range(1, upper));
					end
				end else if (pick < 92) begin
					op  = CMD_FREE;
					len = CNT_W'($urandom_range(0, 511));
				end else if (pick < 96) begin
					len = CNT_W'($urandom_range(0, size_in_use));
				end else begin
					len = CNT_W'($urandom_range(0, 511));
				end
				send_request(op, len, rel, 1'b0, '0, got);
				if (op == CMD_ALLOC && got.status == ST_OK && len != 0)
					held_chains.push_back(got.chain_head);
				items++;
				if (items == 200)
					drain_responses();
			end
		end

		drain_responses();
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
